@@ rtl/fla_pkg.sv @@
`timescale 1ns / 1ps

package fla_pkg;

    // Width of the IEEE single-precision bit pattern and of the result.
    localparam int FLOAT_W = 32;
    localparam int VALUE_W = 32;

    // Fixed-point formats: coefficients in Q4.28, significand in Q0.24.
    localparam int COEF_SHIFT = 28;
    localparam int MANT_SHIFT = 24;
    localparam int COEF_W     = 32;
    localparam int MANT_W     = 24;
    localparam int EXP_W      = 9;
    localparam int L2_W       = 28;

    localparam int FRAC_BITS_DEFAULT = 24;

    // Cubic coefficients of the log2 approximation, nearest integer to c * 2^28.
    localparam logic signed [COEF_W-1:0] POLY_C0 = 32'sd330577167;
    localparam logic signed [COEF_W-1:0] POLY_C1 = -32'sd1105558180;
    localparam logic signed [COEF_W-1:0] POLY_C2 = 32'sd1616510301;
    localparam logic signed [COEF_W-1:0] POLY_C3 = -32'sd841267190;

    // log10(2) in Q0.28.
    localparam logic signed [L2_W-1:0] LOG10_TWO = 28'sd80807124;

    // Largest positive result, used for infinity and NaN.
    localparam logic [VALUE_W-1:0] VALUE_SAT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CLS_FINITE = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } cls_t;

endpackage

@@ rtl/fast_log10_approximation_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Contents
// s_axis    in         s_tvalid s_tready s_tdata[31:0]  float_bits
// m_axis    out        m_tvalid m_tready m_tdata[31:0]  log10_value
//                      m_tuser[1:0]                     input_class
//
// The block is an eleven-stage pipeline and accepts one item in every cycle
// unless every stage is full and the output is stalled. Most stages hold the
// three Horner multiply-and-round steps and the final multiply by log10(2),
// each split over two stages.
// Reset (rst_n low, asynchronous) empties the pipeline; no payload is kept.
// A stall on m_tready holds each occupied stage; empty stages keep filling,
// so bubbles close up and s_tready drops only when every stage is full.

module fast_log10_approximation_top #(
    parameter int FRAC_BITS = fla_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [fla_pkg::FLOAT_W-1:0] s_tdata,   // [31:0] float_bits
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fla_pkg::VALUE_W-1:0] m_tdata,   // [31:0] log10_value
    output logic [1:0]                  m_tuser    // [1:0] input_class
);

    import fla_pkg::*;

    localparam int NST     = 11;
    localparam int PM_W    = COEF_W + MANT_W + 1;   // product of Q4.28 and Q0.24
    localparam int PL_W    = COEF_W + L2_W;         // product of Q4.28 and log10(2)
    localparam int EL_W    = EXP_W + L2_W;          // exponent times log10(2)
    localparam int SUM_W   = 64;
    localparam int OUT_SH  = 2 * COEF_SHIFT - FRAC_BITS;

    localparam logic signed [PM_W-1:0]  MANT_HALF = PM_W'(64'd1 << (MANT_SHIFT - 1));
    localparam logic signed [SUM_W-1:0] OUT_HALF  = SUM_W'(64'd1 << (OUT_SH - 1));

    // Left shift that moves the highest set bit of a 23-bit fraction up to
    // bit 23 of the significand.
    function automatic logic [4:0] lead_zeros(input logic [22:0] f);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (f[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    // Handshake chain: a stage loads when it is empty or the next one moves on.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Class travels with every stage.
    cls_t cls_reg [NST];

    // Stage payloads.
    logic [7:0]               expo0_reg;
    logic [22:0]              frac0_reg;
    logic [7:0]               expo1_reg;
    logic [22:0]              frac1_reg;
    logic [4:0]               lz1_reg;
    logic [MANT_W-1:0]        mant2_reg, mant3_reg, mant4_reg, mant5_reg, mant6_reg;
    logic signed [EXP_W-1:0]  e2_reg;
    logic signed [PM_W-1:0]   p3_reg, p5_reg, p7_reg;
    logic signed [COEF_W-1:0] y4_reg, y6_reg, y8_reg;
    logic signed [EL_W-1:0]   el3_reg, el4_reg, el5_reg, el6_reg, el7_reg, el8_reg, el9_reg;
    logic signed [PL_W-1:0]   pl9_reg;
    logic [VALUE_W-1:0]       out10_reg;

    // Combinational values of each stage.
    cls_t                     cls0_next;
    logic [MANT_W-1:0]        mant2_next;
    logic signed [EXP_W-1:0]  e2_next;
    logic signed [COEF_W-1:0] y4_next, y6_next, y8_next;
    logic signed [SUM_W-1:0]  sum10;
    logic signed [SUM_W-1:0]  r10;
    logic [VALUE_W-1:0]       out10_next;

    always_comb
    begin
        priority if (s_tdata[30:23] == 8'hFF)
        begin
            cls0_next = (s_tdata[22:0] == '0) ? CLS_INF : CLS_NAN;
        end
        else if (s_tdata[30:0] == '0)
        begin
            cls0_next = CLS_ZERO;
        end
        else
        begin
            cls0_next = CLS_FINITE;
        end
    end

    // Normalize denormals; zero gets F = 0 and E = 0.
    always_comb
    begin
        if (cls_reg[1] == CLS_ZERO)
        begin
            mant2_next = '0;
            e2_next    = '0;
        end
        else if (expo1_reg == 8'd0)
        begin
            mant2_next = MANT_W'({1'b0, frac1_reg} << lz1_reg);
            e2_next    = -EXP_W'(125) - $signed({4'b0, lz1_reg});
        end
        else
        begin
            mant2_next = {1'b1, frac1_reg};
            e2_next    = $signed({1'b0, expo1_reg}) - EXP_W'(126);
        end
    end

    // Horner steps: round half up, then add the next coefficient.
    assign y4_next = COEF_W'((p3_reg + MANT_HALF) >>> MANT_SHIFT) + POLY_C1;
    assign y6_next = COEF_W'((p5_reg + MANT_HALF) >>> MANT_SHIFT) + POLY_C2;
    assign y8_next = COEF_W'((p7_reg + MANT_HALF) >>> MANT_SHIFT) + POLY_C3;

    // The exponent term E * log10(2) is kept apart and joins at the end.
    assign sum10 = SUM_W'(pl9_reg) + (SUM_W'(el9_reg) <<< COEF_SHIFT) + OUT_HALF;
    assign r10   = sum10 >>> OUT_SH;

    always_comb
    begin
        if (cls_reg[9] == CLS_INF || cls_reg[9] == CLS_NAN)
        begin
            out10_next = VALUE_SAT;
        end
        else
        begin
            out10_next = r10[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            cls_reg[0] <= cls0_next;
            expo0_reg  <= s_tdata[30:23];
            frac0_reg  <= s_tdata[22:0];
        end
        for (int i = 1; i < NST; i++) begin
            if (rdy[i])
            begin
                cls_reg[i] <= cls_reg[i-1];
            end
        end
        if (rdy[1])
        begin
            expo1_reg <= expo0_reg;
            frac1_reg <= frac0_reg;
            lz1_reg   <= lead_zeros(frac0_reg);
        end
        if (rdy[2])
        begin
            mant2_reg <= mant2_next;
            e2_reg    <= e2_next;
        end
        if (rdy[3])
        begin
            mant3_reg <= mant2_reg;
            p3_reg    <= PM_W'(POLY_C0 * $signed({1'b0, mant2_reg}));
            el3_reg   <= EL_W'(e2_reg * LOG10_TWO);
        end
        if (rdy[4])
        begin
            mant4_reg <= mant3_reg;
            y4_reg    <= y4_next;
            el4_reg   <= el3_reg;
        end
        if (rdy[5])
        begin
            mant5_reg <= mant4_reg;
            p5_reg    <= PM_W'(y4_reg * $signed({1'b0, mant4_reg}));
            el5_reg   <= el4_reg;
        end
        if (rdy[6])
        begin
            mant6_reg <= mant5_reg;
            y6_reg    <= y6_next;
            el6_reg   <= el5_reg;
        end
        if (rdy[7])
        begin
            p7_reg  <= PM_W'(y6_reg * $signed({1'b0, mant6_reg}));
            el7_reg <= el6_reg;
        end
        if (rdy[8])
        begin
            y8_reg  <= y8_next;
            el8_reg <= el7_reg;
        end
        if (rdy[9])
        begin
            pl9_reg <= PL_W'(y8_reg * LOG10_TWO);
            el9_reg <= el8_reg;
        end
        if (rdy[10])
        begin
            out10_reg <= out10_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out10_reg;
    assign m_tuser  = cls_reg[NST-1];

    // A normalized finite significand always has its top bit set.
    a_mant_norm : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && cls_reg[2] == CLS_FINITE |-> mant2_reg[MANT_W-1])
        else $error("finite significand not normalized");

    // Zero enters the polynomial with F = 0 and E = 0.
    a_zero_mant : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && cls_reg[2] == CLS_ZERO |-> mant2_reg == '0 && e2_reg == '0)
        else $error("zero input not mapped to F = 0, E = 0");

    // Infinity and NaN leave saturated.
    a_sat_out : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == CLS_INF || m_tuser == CLS_NAN) |-> m_tdata == VALUE_SAT)
        else $error("special input not saturated");

    // The input side stalls only when every stage holds an item.
    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg) && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the fast log10 pipeline.
//
// Every accepted float pattern is run through a predictor of the block's
// arithmetic. The predictor splits the pattern into a significand and an
// exponent, runs the cubic Horner evaluation in Q4.28 with round-half-up
// steps, and scales the result by log10(2). The expected item goes into a
// queue, and every item that leaves the block is compared field by field
// with the oldest expected item.
//
// Stimulus starts with a short table of directed patterns: zeros of both
// signs, denormals at both ends, powers of two, the largest finite values,
// and infinities and NaNs of both signs. Where the expected output is obvious
// (saturated results for infinity and NaN) the table holds it directly. The
// random part follows in four phases that differ in how often the sender
// idles and how often the receiver stalls. Between phases the sender holds
// off until every expected item has come back.

module testbench;

    import fla_pkg::*;

    localparam int FRAC_BITS  = 24;
    localparam int PHASES     = 4;
    localparam int PER_PHASE  = 358;
    localparam int IDLE_LIMIT = 2000;  // Cycles with no handshake before giving up.
    localparam int DRAIN_WAIT = 20;    // More than the pipeline depth.

    // One output item of the block.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        cls_t               cls;
    } log10_result_t;

    // One row of the directed table. When known is set, the expected output is
    // taken from the row instead of the predictor.
    typedef struct packed {
        logic [FLOAT_W-1:0] bits;
        bit                 known;
        logic [VALUE_W-1:0] value;
        cls_t               cls;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [FLOAT_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    log10_result_t pending_results[$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;

    // Phase settings: no idling, sender mostly idle, receiver mostly stalled,
    // and both occasionally.
    int phase_send_idle[PHASES]  = '{0, 84, 0, 16};
    int phase_recv_stall[PHASES] = '{0, 0, 84, 16};

    directed_row_t directed_rows[20] = '{
        '{32'h0000_0000, 1'b0, 32'h0, CLS_FINITE},  // positive zero
        '{32'h8000_0000, 1'b0, 32'h0, CLS_FINITE},  // negative zero
        '{32'h0000_0001, 1'b0, 32'h0, CLS_FINITE},  // smallest denormal
        '{32'h007F_FFFF, 1'b0, 32'h0, CLS_FINITE},  // largest denormal
        '{32'h0040_0000, 1'b0, 32'h0, CLS_FINITE},  // denormal, single shift
        '{32'h8000_0001, 1'b0, 32'h0, CLS_FINITE},  // negative denormal
        '{32'h0080_0000, 1'b0, 32'h0, CLS_FINITE},  // smallest normal
        '{32'h3F00_0000, 1'b0, 32'h0, CLS_FINITE},  // 0.5
        '{32'h3F80_0000, 1'b0, 32'h0, CLS_FINITE},  // 1.0
        '{32'hBF80_0000, 1'b0, 32'h0, CLS_FINITE},  // -1.0
        '{32'h4120_0000, 1'b0, 32'h0, CLS_FINITE},  // 10.0
        '{32'h3FFF_FFFF, 1'b0, 32'h0, CLS_FINITE},  // full significand
        '{32'h7F7F_FFFF, 1'b0, 32'h0, CLS_FINITE},  // largest finite
        '{32'hFF7F_FFFF, 1'b0, 32'h0, CLS_FINITE},  // largest finite, negative
        '{32'h7F80_0000, 1'b1, VALUE_SAT, CLS_INF}, // positive infinity
        '{32'hFF80_0000, 1'b1, VALUE_SAT, CLS_INF}, // negative infinity
        '{32'h7F80_0001, 1'b1, VALUE_SAT, CLS_NAN}, // signaling NaN
        '{32'h7FC0_0000, 1'b1, VALUE_SAT, CLS_NAN}, // quiet NaN
        '{32'hFFFF_FFFF, 1'b1, VALUE_SAT, CLS_NAN}, // NaN with full payload
        '{32'hFFC0_0000, 1'b1, VALUE_SAT, CLS_NAN}  // negative quiet NaN
    };

    fast_log10_approximation_top #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor(x / 2^s + 1/2): ties round toward plus infinity.
    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Expected output for one float pattern.
    function automatic log10_result_t predict_log10(logic [FLOAT_W-1:0] bits);
        logic [7:0]    expo;
        logic [22:0]   frac;
        logic [23:0]   mant;
        longint        expn;
        longint        acc;
        longint        coefs[4];
        log10_result_t res;

        expo = bits[30:23];
        frac = bits[22:0];
        res.cls = CLS_FINITE;

        // Infinity and NaN saturate; only the class tells them apart.
        if (expo == 8'hFF)
        begin
            res.value = VALUE_SAT;
            res.cls   = (frac == 23'd0) ? CLS_INF : CLS_NAN;
            return res;
        end

        if (expo == 8'd0 && frac == 23'd0)
        begin
            // Zero runs through the polynomial with a zero significand.
            mant    = 24'd0;
            expn    = 0;
            res.cls = CLS_ZERO;
        end
        else if (expo == 8'd0)
        begin
            // Denormal: shift until the top bit is set, one exponent step each.
            mant = {1'b0, frac};
            expn = -125;
            while (!mant[23])
            begin
                mant = mant << 1;
                expn = expn - 1;
            end
        end
        else
        begin
            mant = {1'b1, frac};
            expn = longint'(expo) - 126;
        end

        coefs[0] = longint'(POLY_C0);
        coefs[1] = longint'(POLY_C1);
        coefs[2] = longint'(POLY_C2);
        coefs[3] = longint'(POLY_C3);

        acc = coefs[0];
        for (int k = 1; k < 4; k++)
            acc = round_half_up(acc * longint'(mant), MANT_SHIFT) + coefs[k];
        acc = acc + expn * (longint'(1) <<< COEF_SHIFT);
        acc = round_half_up(acc * longint'(LOG10_TWO), 2 * COEF_SHIFT - FRAC_BITS);

        res.value = acc[VALUE_W-1:0];
        return res;
    endfunction

    // Random pattern, weighted toward denormals, zeros, specials and powers of two.
    function automatic logic [FLOAT_W-1:0] random_float();
        logic [FLOAT_W-1:0] bits;
        int                 pick;

        bits = $urandom;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // Denormals with a spread of leading zero counts, zero included.
            bits[30:23] = 8'h00;
            bits[22:0]  = 23'($urandom >> $urandom_range(9, 31));
        end
        else if (pick < 14)
        begin
            bits[30:23] = 8'hFF;
            if ($urandom_range(1) == 0)
                bits[22:0] = 23'd0;
        end
        else if (pick < 18)
        begin
            bits[22:0] = 23'd0;
        end
        return bits;
    endfunction

    // Present one item, honoring the sender idle rate, and record what the
    // block should return once the handshake has happened.
    task automatic send_item(logic [FLOAT_W-1:0] bits, bit known, log10_result_t fixed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (known)
            pending_results.push_back(fixed);
        else
            pending_results.push_back(predict_log10(bits));
    endtask

    // Hold off until the block has returned every expected item.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The receiver stalls at random, redrawn every cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Output check: each handshake is compared with the oldest expected item.
    always @(posedge clk)
    begin
        log10_result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected item value=%h class=%0d",
                             $realtime, m_tdata, m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.cls)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch value exp=%h got=%h class exp=%0d got=%0d",
                                 $realtime, want.value, m_tdata, want.cls, m_tuser);
                end
            end
        end
    end

    // Watchdog: a run of cycles with no handshake on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        log10_result_t fixed;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back with no idling.
        foreach (directed_rows[i])
        begin
            fixed.value = directed_rows[i].value;
            fixed.cls   = directed_rows[i].cls;
            send_item(directed_rows[i].bits, directed_rows[i].known, fixed);
        end
        wait_for_drain();

        // Random phases; each ends with the sender waiting for the pipeline
        // to empty, so bubbles and stalls land on every stage.
        for (int p = 0; p < PHASES; p++)
        begin
            sender_idle_pct    = phase_send_idle[p];
            receiver_stall_pct = phase_recv_stall[p];
            for (int n = 0; n < PER_PHASE; n++)
                send_item(random_float(), 1'b0, fixed);
            wait_for_drain();
        end

        // Let any stray output show up before the verdict.
        receiver_stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
